// ----- hdl/cau_pkg.sv -----
// Shared types and constants for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    // Default word format: Q4.28.
    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 28;

    // Operation codes carried on the command field.
    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_RECIP = 3'd4,
        CMD_ABS2  = 3'd5,
        CMD_CONJ  = 3'd6,
        CMD_EQUAL = 3'd7
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // Control that travels with each item through the pipeline.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic is_eq;
    } t_tag;

    // Width of the exact intermediate values handed from stage to stage.
    function automatic int val_width(input int w, input int f);
        return ((w + f + 2) > (2 * w + 2)) ? (w + f + 2) : (2 * w + 2);
    endfunction

endpackage

// ----- hdl/cau_front.sv -----
// Operand capture, product stage and exact value formation.
`timescale 1ns / 1ps

module cau_front #(
    parameter int WORD_WIDTH = cau_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [2:0]                             i_cmd,
    input  logic signed [WORD_WIDTH-1:0]           i_a_re,
    input  logic signed [WORD_WIDTH-1:0]           i_a_im,
    input  logic signed [WORD_WIDTH-1:0]           i_b_re,
    input  logic signed [WORD_WIDTH-1:0]           i_b_im,
    output cau_pkg::t_tag                          o_tag,
    output logic signed [cau_pkg::val_width(WORD_WIDTH, FRAC_BITS)-1:0] o_v_re,
    output logic signed [cau_pkg::val_width(WORD_WIDTH, FRAC_BITS)-1:0] o_v_im,
    output logic [2*WORD_WIDTH-1:0]                o_den
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W;
    localparam int VW = ((W + F + 2) > (2 * W + 2)) ? (W + F + 2) : (2 * W + 2);

    // Stage A: registered operands.
    cau_pkg::t_tag          r_a_tag, n_a_tag;
    logic signed [W-1:0]    r_a_ar, r_a_ai, r_a_br, r_a_bi;

    // Stage B: products.
    cau_pkg::t_tag          r_b_tag, n_b_tag;
    logic signed [W-1:0]    r_b_ar, r_b_ai, r_b_br, r_b_bi;
    logic signed [PW-1:0]   r_b_p_rr, r_b_p_ii, r_b_p_ir, r_b_p_ri, r_b_sq1, r_b_sq2;
    logic signed [W-1:0]    sq_x, sq_y;

    // Stage C: exact values at twice the fraction bits.
    cau_pkg::t_tag          r_c_tag;
    logic signed [VW-1:0]   r_c_v_re, r_c_v_im, n_c_v_re, n_c_v_im;
    logic [DW-1:0]          r_c_den, n_c_den;
    logic signed [VW-1:0]   x_ar, x_ai, x_br, x_bi;
    logic signed [VW-1:0]   x_rr, x_ii, x_ir, x_ri, x_s1, x_s2;

    // Capture of the incoming transfer.
    always_comb begin
        n_a_tag       = '0;
        n_a_tag.valid = i_valid;
        n_a_tag.cmd   = cau_pkg::t_cmd'(i_cmd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else if (i_en) begin
            r_a_tag <= n_a_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ar <= i_a_re;
            r_a_ai <= i_a_im;
            r_a_br <= i_b_re;
            r_a_bi <= i_b_im;
        end
    end

    // Squares come from b for division and from a otherwise.
    assign sq_x = (r_a_tag.cmd == cau_pkg::CMD_DIV) ? r_a_br : r_a_ar;
    assign sq_y = (r_a_tag.cmd == cau_pkg::CMD_DIV) ? r_a_bi : r_a_ai;

    always_comb begin
        n_b_tag       = r_a_tag;
        n_b_tag.is_eq = (r_a_tag.cmd == cau_pkg::CMD_EQUAL) &&
                        (r_a_ar == r_a_br) && (r_a_ai == r_a_bi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
        end else if (i_en) begin
            r_b_tag <= n_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_ar   <= r_a_ar;
            r_b_ai   <= r_a_ai;
            r_b_br   <= r_a_br;
            r_b_bi   <= r_a_bi;
            r_b_p_rr <= PW'(r_a_ar) * PW'(r_a_br);
            r_b_p_ii <= PW'(r_a_ai) * PW'(r_a_bi);
            r_b_p_ir <= PW'(r_a_ai) * PW'(r_a_br);
            r_b_p_ri <= PW'(r_a_ar) * PW'(r_a_bi);
            r_b_sq1  <= PW'(sq_x) * PW'(sq_x);
            r_b_sq2  <= PW'(sq_y) * PW'(sq_y);
        end
    end

    // Sign-extend everything to the common value width.
    assign x_ar = VW'(r_b_ar);
    assign x_ai = VW'(r_b_ai);
    assign x_br = VW'(r_b_br);
    assign x_bi = VW'(r_b_bi);
    assign x_rr = VW'(r_b_p_rr);
    assign x_ii = VW'(r_b_p_ii);
    assign x_ir = VW'(r_b_p_ir);
    assign x_ri = VW'(r_b_p_ri);
    assign x_s1 = VW'(r_b_sq1);
    assign x_s2 = VW'(r_b_sq2);

    // Per-operation value before rounding or division.
    always_comb begin
        n_c_den  = $unsigned(r_b_sq1) + $unsigned(r_b_sq2);
        n_c_v_re = '0;
        n_c_v_im = '0;
        case (r_b_tag.cmd)
            cau_pkg::CMD_ADD: begin
                n_c_v_re = (x_ar + x_br) <<< F;
                n_c_v_im = (x_ai + x_bi) <<< F;
            end
            cau_pkg::CMD_SUB: begin
                n_c_v_re = (x_ar - x_br) <<< F;
                n_c_v_im = (x_ai - x_bi) <<< F;
            end
            cau_pkg::CMD_MUL: begin
                n_c_v_re = x_rr - x_ii;
                n_c_v_im = x_ir + x_ri;
            end
            cau_pkg::CMD_DIV: begin
                n_c_v_re = x_rr + x_ii;
                n_c_v_im = x_ir - x_ri;
            end
            cau_pkg::CMD_RECIP: begin
                n_c_v_re = x_ar <<< F;
                n_c_v_im = -(x_ai <<< F);
            end
            cau_pkg::CMD_ABS2: begin
                n_c_v_re = x_s1 + x_s2;
            end
            cau_pkg::CMD_CONJ: begin
                n_c_v_re = x_ar <<< F;
                n_c_v_im = -(x_ai <<< F);
            end
            default: begin
                n_c_v_re = '0;
                n_c_v_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag <= '0;
        end else if (i_en) begin
            r_c_tag <= r_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_v_re <= n_c_v_re;
            r_c_v_im <= n_c_v_im;
            r_c_den  <= n_c_den;
        end
    end

    assign o_tag  = r_c_tag;
    assign o_v_re = r_c_v_re;
    assign o_v_im = r_c_v_im;
    assign o_den  = r_c_den;

endmodule

// ----- hdl/cau_norm.sv -----
// Magnitude split, rounding with saturation and divider setup.
`timescale 1ns / 1ps

module cau_norm #(
    parameter int WORD_WIDTH = cau_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  cau_pkg::t_tag                          i_tag,
    input  logic signed [cau_pkg::val_width(WORD_WIDTH, FRAC_BITS)-1:0] i_v_re,
    input  logic signed [cau_pkg::val_width(WORD_WIDTH, FRAC_BITS)-1:0] i_v_im,
    input  logic [2*WORD_WIDTH-1:0]                i_den,
    output cau_pkg::t_tag                          o_tag,
    output logic [1:0]                             o_neg,
    output logic [1:0]                             o_ovf,
    output logic                                   o_dz,
    output logic                                   o_sat,
    output logic [WORD_WIDTH-1:0]                  o_res_re,
    output logic [WORD_WIDTH-1:0]                  o_res_im,
    output logic [1:0][2*WORD_WIDTH-1:0]           o_rem,
    output logic [1:0][WORD_WIDTH:0]               o_low,
    output logic [2*WORD_WIDTH-1:0]                o_den
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W;
    localparam int VW  = ((W + F + 2) > (2 * W + 2)) ? (W + F + 2) : (2 * W + 2);
    localparam int RQW = VW - F;
    localparam int XW  = VW + F + 1;
    localparam int HW  = XW - W - 1;
    localparam int CW  = (HW > DW) ? HW : DW;
    localparam logic [VW-1:0]  HALF    = VW'(1) << (F - 1);
    localparam logic [RQW-1:0] LIM_NEG = RQW'(1) << (W - 1);
    localparam logic [RQW-1:0] LIM_POS = (RQW'(1) << (W - 1)) - RQW'(1);

    // Stage D: sign and magnitude.
    cau_pkg::t_tag          r_d_tag;
    logic [1:0]             r_d_neg;
    logic [1:0][VW-1:0]     r_d_mag;
    logic [DW-1:0]          r_d_den;
    logic                   r_d_dz;

    // Stage E: rounded words and divider start values.
    cau_pkg::t_tag          r_e_tag;
    logic [1:0]             r_e_neg, r_e_ovf, n_e_ovf;
    logic                   r_e_dz, r_e_sat, n_e_sat;
    logic [1:0][W-1:0]      r_e_res, n_e_res;
    logic [1:0][DW-1:0]     r_e_rem, n_e_rem;
    logic [1:0][W:0]        r_e_low, n_e_low;
    logic [DW-1:0]          r_e_den;

    logic                   is_div;
    logic [VW-1:0]          rnd_t;
    logic [RQW-1:0]         rnd_q, rnd_lim, rnd_m, rnd_neg_m;
    logic [XW-1:0]          dvd;
    logic [HW-1:0]          dvd_hi;
    logic [1:0]             rnd_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_tag <= '0;
            r_e_tag <= '0;
        end else if (i_en) begin
            r_d_tag <= i_tag;
            r_e_tag <= r_d_tag;
        end
    end

    // Split each value into a sign and an unsigned magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_neg[0] <= i_v_re[VW-1];
            r_d_neg[1] <= i_v_im[VW-1];
            r_d_mag[0] <= i_v_re[VW-1] ? $unsigned(-i_v_re) : $unsigned(i_v_re);
            r_d_mag[1] <= i_v_im[VW-1] ? $unsigned(-i_v_im) : $unsigned(i_v_im);
            r_d_den    <= i_den;
            r_d_dz     <= (i_den == '0);
        end
    end

    assign is_div = (r_d_tag.cmd == cau_pkg::CMD_DIV) ||
                    (r_d_tag.cmd == cau_pkg::CMD_RECIP);

    // Round half away from zero, saturate, and set up the divider per lane.
    always_comb begin
        n_e_res  = '0;
        n_e_rem  = '0;
        n_e_low  = '0;
        n_e_ovf  = '0;
        rnd_sat  = '0;
        rnd_t    = '0;
        rnd_q    = '0;
        rnd_lim  = '0;
        rnd_m    = '0;
        rnd_neg_m = '0;
        dvd      = '0;
        dvd_hi   = '0;
        for (int l = 0; l < 2; l++) begin
            rnd_t      = r_d_mag[l] + HALF;
            rnd_q      = rnd_t[VW-1:F];
            rnd_lim    = r_d_neg[l] ? LIM_NEG : LIM_POS;
            rnd_sat[l] = (rnd_q > rnd_lim);
            rnd_m      = rnd_sat[l] ? rnd_lim : rnd_q;
            rnd_neg_m  = -rnd_m;
            n_e_res[l] = r_d_neg[l] ? rnd_neg_m[W-1:0] : rnd_m[W-1:0];

            dvd        = {r_d_mag[l], {(F + 1){1'b0}}};
            dvd_hi     = dvd[XW-1:W+1];
            n_e_ovf[l] = (CW'(dvd_hi) >= CW'(r_d_den));
            n_e_rem[l] = n_e_ovf[l] ? '0 : DW'(dvd_hi);
            n_e_low[l] = dvd[W:0];
        end
        n_e_sat = !is_div && (rnd_sat != 2'b00);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_neg <= r_d_neg;
            r_e_ovf <= n_e_ovf;
            r_e_dz  <= r_d_dz && is_div;
            r_e_sat <= n_e_sat;
            r_e_res <= n_e_res;
            r_e_rem <= n_e_rem;
            r_e_low <= n_e_low;
            r_e_den <= r_d_den;
        end
    end

    assign o_tag    = r_e_tag;
    assign o_neg    = r_e_neg;
    assign o_ovf    = r_e_ovf;
    assign o_dz     = r_e_dz;
    assign o_sat    = r_e_sat;
    assign o_res_re = r_e_res[0];
    assign o_res_im = r_e_res[1];
    assign o_rem    = r_e_rem;
    assign o_low    = r_e_low;
    assign o_den    = r_e_den;

endmodule

// ----- hdl/cau_div_step.sv -----
// One restoring-division stage: one quotient bit for each of the two lanes.
`timescale 1ns / 1ps

module cau_div_step #(
    parameter int WORD_WIDTH = cau_pkg::WORD_WIDTH_DEF,
    parameter int SIDE_W     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [1:0][2*WORD_WIDTH-1:0]      i_rem,
    input  logic [1:0][WORD_WIDTH:0]          i_low,
    input  logic [1:0][WORD_WIDTH:0]          i_quo,
    input  logic [2*WORD_WIDTH-1:0]           i_den,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [1:0][2*WORD_WIDTH-1:0]      o_rem,
    output logic [1:0][WORD_WIDTH:0]          o_low,
    output logic [1:0][WORD_WIDTH:0]          o_quo,
    output logic [2*WORD_WIDTH-1:0]           o_den,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int W  = WORD_WIDTH;
    localparam int DW = 2 * W;

    logic                   r_valid;
    logic [1:0][DW-1:0]     r_rem, n_rem;
    logic [1:0][W:0]        r_low, n_low, r_quo, n_quo;
    logic [DW-1:0]          r_den;
    logic [SIDE_W-1:0]      r_side;
    logic [DW:0]            trial, diff;
    logic                   take;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        n_rem = '0;
        n_low = '0;
        n_quo = '0;
        trial = '0;
        diff  = '0;
        take  = 1'b0;
        for (int l = 0; l < 2; l++) begin
            trial    = {i_rem[l], i_low[l][W]};
            diff     = trial - {1'b0, i_den};
            take     = (trial >= {1'b0, i_den});
            n_rem[l] = take ? diff[DW-1:0] : trial[DW-1:0];
            n_low[l] = {i_low[l][W-1:0], 1'b0};
            n_quo[l] = {i_quo[l][W-1:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_low  <= n_low;
            r_quo  <= n_quo;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// ----- hdl/complex_arithmetic_unit.sv -----
// Top level of the pipelined complex-number ALU on signed fixed-point words.
//
// Usage: the input channel (i_valid, o_stall) carries a command and two complex
// operands a and b; the output channel (o_valid, i_stall) returns the real and
// imaginary result, the equality flag and a status code (ok, saturated,
// divide by zero). A transfer happens on a clock edge with valid high and
// stall low.
// Throughput: one item per cycle while o_stall is low. The pipeline depth is
// set by the restoring divider, which spends one stage per quotient bit.
// The whole pipeline advances together; o_stall is high only while a result
// sits in the output register and the receiver stalls, so a stall freezes
// every stage and nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; the block keeps
// no other state, and the first item may be sent in the cycle after reset.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
    parameter int WORD_WIDTH = cau_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_cmd,
    input  logic signed [WORD_WIDTH-1:0] i_a_re,
    input  logic signed [WORD_WIDTH-1:0] i_a_im,
    input  logic signed [WORD_WIDTH-1:0] i_b_re,
    input  logic signed [WORD_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [WORD_WIDTH-1:0] o_r_re,
    output logic signed [WORD_WIDTH-1:0] o_r_im,
    output logic                         o_is_equal,
    output logic [1:0]                   o_status
);

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DW     = 2 * W;
    localparam int VW     = ((W + F + 2) > (2 * W + 2)) ? (W + F + 2) : (2 * W + 2);
    localparam int NSTEP  = W + 1;
    // Side payload: cmd, is_eq, neg[2], ovf[2], dz, sat, two rounded words.
    localparam int SIDE_W = 3 + 1 + 2 + 2 + 1 + 1 + 2 * W;
    localparam logic [W:0] LIM_NEG = (W + 1)'(1) << (W - 1);
    localparam logic [W:0] LIM_POS = ((W + 1)'(1) << (W - 1)) - (W + 1)'(1);

    logic                   en;

    cau_pkg::t_tag          fr_tag;
    logic signed [VW-1:0]   fr_v_re, fr_v_im;
    logic [DW-1:0]          fr_den;

    cau_pkg::t_tag          nm_tag;
    logic [1:0]             nm_neg, nm_ovf;
    logic                   nm_dz, nm_sat;
    logic [W-1:0]           nm_res_re, nm_res_im;
    logic [1:0][DW-1:0]     nm_rem;
    logic [1:0][W:0]        nm_low;
    logic [DW-1:0]          nm_den;

    // Divider chain: index k feeds step k, index NSTEP is the chain end.
    logic [NSTEP:0]                   ch_valid;
    logic [NSTEP:0][1:0][DW-1:0]      ch_rem;
    logic [NSTEP:0][1:0][W:0]         ch_low;
    logic [NSTEP:0][1:0][W:0]         ch_quo;
    logic [NSTEP:0][DW-1:0]           ch_den;
    logic [NSTEP:0][SIDE_W-1:0]       ch_side;

    // Fields unpacked at the chain end.
    logic [2:0]             end_cmd;
    logic                   end_is_eq, end_dz, end_sat;
    logic [1:0]             end_neg, end_ovf;
    logic [W-1:0]           end_res_re, end_res_im;

    logic [1:0][W-1:0]      dq_res;
    logic [1:0]             dq_sat;
    logic [W:0]             dq_m, dq_lim, dq_v, dq_neg_v;

    logic                   r_o_valid;
    logic [W-1:0]           r_o_re, r_o_im, n_o_re, n_o_im;
    logic                   r_o_eq, n_o_eq;
    cau_pkg::t_status       r_o_status, n_o_status;

    // The pipeline moves unless a finished result waits on a stalled receiver.
    assign en      = !r_o_valid || !i_stall;
    assign o_stall = !en;

    cau_front #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_tag   (fr_tag),
        .o_v_re  (fr_v_re),
        .o_v_im  (fr_v_im),
        .o_den   (fr_den)
    );

    cau_norm #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tag    (fr_tag),
        .i_v_re   (fr_v_re),
        .i_v_im   (fr_v_im),
        .i_den    (fr_den),
        .o_tag    (nm_tag),
        .o_neg    (nm_neg),
        .o_ovf    (nm_ovf),
        .o_dz     (nm_dz),
        .o_sat    (nm_sat),
        .o_res_re (nm_res_re),
        .o_res_im (nm_res_im),
        .o_rem    (nm_rem),
        .o_low    (nm_low),
        .o_den    (nm_den)
    );

    // Head of the divider chain.
    assign ch_valid[0] = nm_tag.valid;
    assign ch_rem[0]   = nm_rem;
    assign ch_low[0]   = nm_low;
    assign ch_quo[0]   = '0;
    assign ch_den[0]   = nm_den;
    assign ch_side[0]  = {nm_tag.cmd, nm_tag.is_eq, nm_neg, nm_ovf, nm_dz, nm_sat,
                          nm_res_re, nm_res_im};

    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        cau_div_step #(
            .WORD_WIDTH (WORD_WIDTH),
            .SIDE_W     (SIDE_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_valid[k]),
            .i_rem   (ch_rem[k]),
            .i_low   (ch_low[k]),
            .i_quo   (ch_quo[k]),
            .i_den   (ch_den[k]),
            .i_side  (ch_side[k]),
            .o_valid (ch_valid[k+1]),
            .o_rem   (ch_rem[k+1]),
            .o_low   (ch_low[k+1]),
            .o_quo   (ch_quo[k+1]),
            .o_den   (ch_den[k+1]),
            .o_side  (ch_side[k+1])
        );
    end

    assign {end_cmd, end_is_eq, end_neg, end_ovf, end_dz, end_sat,
            end_res_re, end_res_im} = ch_side[NSTEP];

    // Round the quotient (it carries one extra bit) and saturate per lane.
    always_comb begin
        dq_res   = '0;
        dq_sat   = '0;
        dq_m     = '0;
        dq_lim   = '0;
        dq_v     = '0;
        dq_neg_v = '0;
        for (int l = 0; l < 2; l++) begin
            dq_m      = {1'b0, ch_quo[NSTEP][l][W:1]} + (W + 1)'(ch_quo[NSTEP][l][0]);
            dq_lim    = end_neg[l] ? LIM_NEG : LIM_POS;
            dq_sat[l] = end_ovf[l] || (dq_m > dq_lim);
            dq_v      = dq_sat[l] ? dq_lim : dq_m;
            dq_neg_v  = -dq_v;
            dq_res[l] = end_neg[l] ? dq_neg_v[W-1:0] : dq_v[W-1:0];
        end
    end

    // Select the result for the operation and build the status.
    always_comb begin
        n_o_re     = end_res_re;
        n_o_im     = end_res_im;
        n_o_eq     = 1'b0;
        n_o_status = end_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        case (end_cmd)
            cau_pkg::CMD_DIV, cau_pkg::CMD_RECIP: begin
                if (end_dz) begin
                    n_o_re     = '0;
                    n_o_im     = '0;
                    n_o_status = cau_pkg::ST_DIV0;
                end else begin
                    n_o_re     = dq_res[0];
                    n_o_im     = dq_res[1];
                    n_o_status = (dq_sat != 2'b00) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::CMD_EQUAL: begin
                n_o_re     = '0;
                n_o_im     = '0;
                n_o_eq     = end_is_eq;
                n_o_status = cau_pkg::ST_OK;
            end
            default: begin
                n_o_re = end_res_re;
                n_o_im = end_res_im;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= ch_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_re     <= n_o_re;
            r_o_im     <= n_o_im;
            r_o_eq     <= n_o_eq;
            r_o_status <= n_o_status;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_r_re     = r_o_re;
    assign o_r_im     = r_o_im;
    assign o_is_equal = r_o_eq;
    assign o_status   = r_o_status;

endmodule

// ----- hdl/cau_checker.sv -----
// Port-level checks for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module cau_checker #(
    parameter int WORD_WIDTH = cau_pkg::WORD_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [2:0]                   i_cmd,
    input logic signed [WORD_WIDTH-1:0] i_a_re,
    input logic signed [WORD_WIDTH-1:0] i_a_im,
    input logic signed [WORD_WIDTH-1:0] i_b_re,
    input logic signed [WORD_WIDTH-1:0] i_b_im,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [WORD_WIDTH-1:0] o_r_re,
    input logic signed [WORD_WIDTH-1:0] o_r_im,
    input logic                         o_is_equal,
    input logic [1:0]                   o_status
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The input side only backs up behind a stalled, waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // A result held by the receiver does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_r_re) && $stable(o_r_im) &&
                                  $stable(o_status) && $stable(o_is_equal)))
        else $error("stalled result changed");

    // A divide by zero returns zero parts and no equality.
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == cau_pkg::ST_DIV0)) |->
            ((o_r_re == '0) && (o_r_im == '0) && !o_is_equal))
        else $error("divide by zero with nonzero result");

    // Equality results carry zero parts and an ok status.
    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_equal) |->
            ((o_r_re == '0) && (o_r_im == '0) && (o_status == cau_pkg::ST_OK)))
        else $error("equality result with data or status");

endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_WIDTH(WORD_WIDTH)) u_cau_checker (.*);
